FILE: sv/fsp_pkg.sv
// Package with shared types, constants and the CORDIC arctangent table.
`timescale 1ns / 1ps
package fsp_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 18;
    localparam int SQRT_STEPS   = 17;
    localparam int FRAC_BITS    = 16;
    localparam logic [31:0] GOLDEN_TURN = 32'h61C88647;
    localparam logic signed [33:0] CORDIC_ONE = 34'sh026DD3B6A;

    typedef enum logic [0:0] {
        REG_POINT_COUNT   = 1'b0,
        REG_SPHERE_RADIUS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    typedef struct packed {
        logic [17:0] rem;
        logic [17:0] quo;
        logic [15:0] den;
        logic [35:0] num;
    } div_t;

    typedef struct packed {
        logic [35:0] rad;
        logic [35:0] bitv;
        logic [35:0] res;
    } sqrt_t;

    typedef struct packed {
        logic        oor;
        logic        flip;
        logic        zero_den;
        logic [15:0] idx;
        logic [15:0] radius;
    } side_t;

    function automatic logic signed [33:0] atan_turn(input int k);
        logic signed [33:0] r;
        begin
            unique case (k)
                0: r = 34'sh020000000;  1: r = 34'sh012E4051E;
                2: r = 34'sh009FB385B;  3: r = 34'sh0051111D4;
                4: r = 34'sh0028B0D43;  5: r = 34'sh00145D7E1;
                6: r = 34'sh000A2F61E;  7: r = 34'sh000517C55;
                8: r = 34'sh00028BE53;  9: r = 34'sh000145F2F;
                10: r = 34'sh0000A2F98; 11: r = 34'sh0000517CC;
                12: r = 34'sh000028BE6; 13: r = 34'sh0000145F3;
                14: r = 34'sh00000A2FA; 15: r = 34'sh00000517D;
                16: r = 34'sh0000028BE; 17: r = 34'sh00000145F;
                18: r = 34'sh000000A30; 19: r = 34'sh000000518;
                20: r = 34'sh00000028C; 21: r = 34'sh000000146;
                22: r = 34'sh0000000A3; 23: r = 34'sh000000051;
                24: r = 34'sh000000029; 25: r = 34'sh000000014;
                26: r = 34'sh00000000A; 27: r = 34'sh000000005;
                28: r = 34'sh000000003; 29: r = 34'sh000000001;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: sv/fsp_if.sv
// Valid/ready channel interfaces for index items, point items and register writes.
`timescale 1ns / 1ps
interface fsp_index_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_index;
    modport source (output valid, point_index, input ready);
    modport sink (input valid, point_index, output ready);
endinterface

interface fsp_point_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] coord_x;
    logic signed [16:0] coord_y;
    logic signed [16:0] coord_z;
    logic               index_out_of_range;
    modport source (output valid, coord_x, coord_y, coord_z, index_out_of_range,
                    input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, index_out_of_range,
                  output ready);
endinterface

interface fsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/fsp_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage.
`timescale 1ns / 1ps
module fsp_div_cell (
    input  logic          clk,
    input  logic          en,
    input  fsp_pkg::div_t din,
    output fsp_pkg::div_t dout
);
    import fsp_pkg::*;

    logic [17:0] shifted;
    logic [18:0] diff;
    div_t        next_v;

    always_comb
    begin
        shifted = {din.rem[16:0], din.num[35]};
        diff    = {1'b0, shifted} - {3'b000, din.den};
        next_v  = din;
        next_v.num = {din.num[34:0], 1'b0};
        if (!diff[18])
        begin
            next_v.rem = diff[17:0];
            next_v.quo = {din.quo[16:0], 1'b1};
        end
        else
        begin
            next_v.rem = shifted;
            next_v.quo = {din.quo[16:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= next_v;
    end
endmodule

FILE: sv/fsp_sqrt_cell.sv
// One integer square-root cell: decides one result bit per stage.
`timescale 1ns / 1ps
module fsp_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  fsp_pkg::sqrt_t din,
    output fsp_pkg::sqrt_t dout
);
    import fsp_pkg::*;

    logic [35:0] trial;
    sqrt_t       next_v;

    always_comb
    begin
        trial  = din.res + din.bitv;
        next_v = din;
        if (din.rad >= trial)
        begin
            next_v.rad = din.rad - trial;
            next_v.res = (din.res >> 1) + din.bitv;
        end
        else
            next_v.res = din.res >> 1;
        next_v.bitv = din.bitv >> 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= next_v;
    end
endmodule

FILE: sv/fsp_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift and arctangent.
`timescale 1ns / 1ps
module fsp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  fsp_pkg::cordic_t din,
    output fsp_pkg::cordic_t dout
);
    import fsp_pkg::*;

    localparam logic signed [33:0] ATAN = atan_turn(STEP);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    cordic_t            next_v;

    always_comb
    begin
        dx = din.y >>> STEP;
        dy = din.x >>> STEP;
        if (!din.z[33])
        begin
            next_v.x = din.x - dx;
            next_v.y = din.y + dy;
            next_v.z = din.z - ATAN;
        end
        else
        begin
            next_v.x = din.x + dx;
            next_v.y = din.y - dy;
            next_v.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= next_v;
    end
endmodule

FILE: sv/fibonacci_sphere_points.sv
// Fibonacci sphere lattice point generator built as rows of pipeline cells.
// Throughput: one item per cycle; the division row followed by the square-root
// row sets the depth, and the CORDIC results wait in a short delay line.
// The whole pipeline advances together and stalls when the output is held.
// Reset clears valid bits; point_count resets to 1000, sphere_radius to 256.
`timescale 1ns / 1ps
module fibonacci_sphere_points #(
    parameter int MAX_POINTS = 65536
) (
    input  logic clk,
    input  logic rst_n,
    fsp_index_if.sink   in_ch,
    fsp_point_if.source out_ch,
    fsp_cfg_if.sink     cfg
);
    import fsp_pkg::*;

    // Stages: 0 entry, 1..18 division, 19 y and square-root operand, 20..36 square
    // root (CORDIC in 1..30, then delayed), 37 products with ring, 38 round and
    // clamp, 39 radius products, 40 output.
    localparam int RING_STAGE = DIV_STEPS + SQRT_STEPS + 1;
    localparam int CDELAY     = RING_STAGE - CORDIC_STEPS;
    localparam int DEPTH      = RING_STAGE + 5;

    logic [15:0] point_count_reg;
    logic [15:0] sphere_radius_reg;
    logic [DEPTH-1:0] vld_reg;
    logic        adv;

    assign adv          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready  = adv;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= 16'd1000;
            sphere_radius_reg <= 16'd256;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_POINT_COUNT:   point_count_reg   <= cfg.data;
                REG_SPHERE_RADIUS: sphere_radius_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end
    assign out_ch.valid = vld_reg[DEPTH-1];

    // Entry stage.
    side_t       side_next;
    logic [31:0] turn;
    logic [31:0] res_turn;
    logic        flip;
    cordic_t     cin;
    div_t        din0;
    logic [15:0] dcount;
    logic [35:0] dnum;

    always_comb
    begin
        dcount   = point_count_reg - 16'd1;
        turn     = in_ch.point_index * GOLDEN_TURN;
        flip     = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
        res_turn = flip ? turn - 32'h80000000 : turn;
        cin.x    = CORDIC_ONE;
        cin.y    = '0;
        cin.z    = {{2{res_turn[31]}}, res_turn};
        side_next.oor = (in_ch.point_index >= point_count_reg) ||
                        (32'(in_ch.point_index) >= 32'(MAX_POINTS));
        side_next.flip     = flip;
        side_next.zero_den = (dcount == 16'd0);
        side_next.idx      = in_ch.point_index;
        side_next.radius   = sphere_radius_reg;
        dnum     = 36'({in_ch.point_index, 17'd0}) + 36'(dcount[15:1]);
        // The quotient fits in 18 bits, so the upper half starts as the remainder.
        din0.rem = dnum[35:18];
        din0.quo = '0;
        din0.den = side_next.zero_den ? 16'd1 : dcount;
        din0.num = {dnum[17:0], 18'd0};
    end

    side_t   side_reg [DEPTH-1];
    cordic_t crow [CORDIC_STEPS+1];
    div_t    drow [DIV_STEPS+1];
    sqrt_t   srow [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            crow[0]     <= cin;
            drow[0]     <= din0;
            for (int k = 1; k < DEPTH-1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            fsp_cordic_cell #(.STEP(g)) u_cell (
                .clk(clk), .en(adv), .din(crow[g]), .dout(crow[g+1]));
        end
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            fsp_div_cell u_cell (
                .clk(clk), .en(adv), .din(drow[g]), .dout(drow[g+1]));
        end
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            fsp_sqrt_cell u_cell (
                .clk(clk), .en(adv), .din(srow[g]), .dout(srow[g+1]));
        end
    endgenerate

    // Division ends after stage 18; y and the square-root operand form in stage 19.
    logic signed [17:0] yu_c;
    logic [17:0]        ay;
    logic [35:0]        ysq;
    logic signed [17:0] yu_pipe [RING_STAGE-DIV_STEPS];

    always_comb
    begin
        yu_c = side_reg[DIV_STEPS].zero_den ? 18'sd65536
             : 18'sd65536 - $signed(drow[DIV_STEPS].quo);
        ay   = yu_c[17] ? 18'(-yu_c) : 18'(yu_c);
        ysq  = ay * ay;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srow[0].rad  <= 36'h100000000 - ysq;
            srow[0].bitv <= 36'h100000000;
            srow[0].res  <= '0;
            yu_pipe[0] <= yu_c;
            for (int k = 1; k < RING_STAGE-DIV_STEPS; k++)
                yu_pipe[k] <= yu_pipe[k-1];
        end
    end

    // The CORDIC row ends at stage 30; its results wait for the ring at stage 36.
    logic signed [33:0] cval;
    logic signed [33:0] sval;
    logic signed [33:0] cpipe [CDELAY];
    logic signed [33:0] spipe [CDELAY];
    logic signed [51:0] cp_reg;
    logic signed [51:0] sp_reg;
    side_t              s31;

    always_comb
    begin
        s31  = side_reg[CORDIC_STEPS];
        cval = s31.flip ? -crow[CORDIC_STEPS].x : crow[CORDIC_STEPS].x;
        sval = s31.flip ? -crow[CORDIC_STEPS].y : crow[CORDIC_STEPS].y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cpipe[0] <= cval;
            spipe[0] <= sval;
            for (int k = 1; k < CDELAY; k++)
            begin
                cpipe[k] <= cpipe[k-1];
                spipe[k] <= spipe[k-1];
            end
        end
    end

    logic signed [17:0] y32_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_reg  <= cpipe[CDELAY-1] * $signed({1'b0, srow[SQRT_STEPS].res[16:0]});
            sp_reg  <= spipe[CDELAY-1] * $signed({1'b0, srow[SQRT_STEPS].res[16:0]});
            y32_reg <= yu_pipe[RING_STAGE-DIV_STEPS-1];
        end
    end

    function automatic logic signed [17:0] round_clamp(input logic signed [51:0] v);
        logic signed [51:0] r;
        begin
            r = (v + 52'sd536870912) >>> 30;
            if (r > 52'sd65536)
                return 18'sd65536;
            else if (r < -52'sd65536)
                return -18'sd65536;
            else
                return r[17:0];
        end
    endfunction

    logic signed [17:0] xu_reg;
    logic signed [17:0] zu_reg;
    logic signed [17:0] y33_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xu_reg  <= round_clamp(cp_reg);
            zu_reg  <= round_clamp(sp_reg);
            y33_reg <= y32_reg;
        end
    end

    logic signed [34:0] px_reg;
    logic signed [34:0] py_reg;
    logic signed [34:0] pz_reg;
    logic signed [16:0] rad_s;
    assign rad_s = $signed({1'b0, side_reg[RING_STAGE+2].radius});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= xu_reg * rad_s;
            py_reg <= y33_reg * rad_s;
            pz_reg <= zu_reg * rad_s;
        end
    end

    function automatic logic signed [16:0] round_out(input logic signed [34:0] v);
        logic signed [34:0] r;
        begin
            r = (v + (35'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            return r[16:0];
        end
    endfunction

    logic        oor_last;
    assign oor_last = side_reg[DEPTH-2].oor;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ch.coord_x <= oor_last ? 17'sd0 : round_out(px_reg);
            out_ch.coord_y <= oor_last ? 17'sd0 : round_out(py_reg);
            out_ch.coord_z <= oor_last ? 17'sd0 : round_out(pz_reg);
            out_ch.index_out_of_range <= oor_last;
        end
    end
endmodule

FILE: tb/tb_fibonacci_sphere_points.sv
// Self-checking testbench for the Fibonacci sphere lattice point generator.
`timescale 1ns / 1ps
module tb_fibonacci_sphere_points;
    import fsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 40;

    typedef struct {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic               oor;
    } point_t;

    // Arctangents in units of 2^-32 turn, one per rotation step.
    localparam longint ANGLE_STEP [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    class lattice_scoreboard;
        point_t      pending_points[$];
        int unsigned num_points = 1000;
        int unsigned radius_q88 = 256;
        int          mismatches = 0;

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp_unit(longint v);
            if (v > 65536)
                return 65536;
            if (v < -65536)
                return -65536;
            return v;
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = longint'(1) << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function point_t lattice_point(logic [15:0] idx);
            point_t          p;
            longint unsigned d;
            longint unsigned quo;
            longint          yu;
            longint          ay;
            longint          ring;
            logic [31:0]     turn;
            logic [31:0]     folded;
            bit              flip;
            longint          cx;
            longint          cy;
            longint          ang;
            longint          dx;
            longint          dy;
            longint          xu;
            longint          zu;
            p = '{x: 0, y: 0, z: 0, oor: 1'b1};
            if (idx >= num_points)
                return p;
            d = num_points - 1;
            quo = (d == 0) ? 0 : (((longint'(idx)) << 17) + d / 2) / d;
            yu = 65536 - longint'(quo);
            ay = (yu < 0) ? -yu : yu;
            ring = int_sqrt(longint'(65536) * 65536 - ay * ay);
            // The angle is folded into the right half plane before rotating.
            turn = idx * GOLDEN_TURN;
            flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
            folded = flip ? turn - 32'h80000000 : turn;
            ang = longint'($signed(folded));
            cx = CORDIC_ONE;
            cy = 0;
            for (int k = 0; k < 30; k++)
            begin
                dx = cy >>> k;
                dy = cx >>> k;
                if (ang >= 0)
                begin
                    cx -= dx;
                    cy += dy;
                    ang -= ANGLE_STEP[k];
                end
                else
                begin
                    cx += dx;
                    cy -= dy;
                    ang += ANGLE_STEP[k];
                end
            end
            if (flip)
            begin
                cx = -cx;
                cy = -cy;
            end
            xu = clamp_unit(round_shift(cx * ring, 30));
            zu = clamp_unit(round_shift(cy * ring, 30));
            p.x = 17'(round_shift(xu * radius_q88, 16));
            p.y = 17'(round_shift(yu * radius_q88, 16));
            p.z = 17'(round_shift(zu * radius_q88, 16));
            p.oor = 1'b0;
            return p;
        endfunction

        function void note_index(logic [15:0] idx);
            pending_points.push_back(lattice_point(idx));
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected point item x=%0d y=%0d z=%0d oor=%0b",
                             got.x, got.y, got.z, got.oor);
                return;
            end
            want = pending_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.oor !== want.oor)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: point expected (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                             want.x, want.y, want.z, want.oor,
                             got.x, got.y, got.z, got.oor);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned cycles = 0;
    bit idle_en = 1'b1;
    int long_hold_req = 0;
    lattice_scoreboard sb = new();

    fsp_index_if in_ch();
    fsp_point_if out_ch();
    fsp_cfg_if   cfg();

    fibonacci_sphere_points DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_fibonacci_sphere_points NOT OK");
            $finish;
        end
    end

    // Receiver: random short stalls, plus one long hold-off on request.
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        if (long_hold_req > 0 && !hold_done)
        begin
            hold_left = long_hold_req;
            hold_done = 1'b1;
        end
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_point('{x: out_ch.coord_x, y: out_ch.coord_y,
                             z: out_ch.coord_z, oor: out_ch.index_out_of_range});
    end

    task automatic send_index(logic [15:0] idx);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.point_index <= idx;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_index(idx);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        @(posedge clk);
        while (sb.pending_points.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t r, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= r;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (r == REG_POINT_COUNT)
            sb.num_points = value;
        else
            sb.radius_q88 = value;
        @(posedge clk);
    endtask

    task automatic set_lattice(logic [15:0] n, logic [15:0] r);
        write_reg(REG_POINT_COUNT, n);
        write_reg(REG_SPHERE_RADIUS, r);
    endtask

    task automatic random_points(int count);
        logic [15:0] idx;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                idx = (sb.num_points < 65535) ?
                      16'($urandom_range(sb.num_points, 65535)) : 16'hFFFF;
            else
                idx = 16'($urandom_range(0, sb.num_points - 1));
            send_index(idx);
        end
    endtask

    initial
    begin
        logic [15:0] n;
        logic [15:0] r;
        in_ch.valid = 1'b0;
        in_ch.point_index = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_POINT_COUNT;
        cfg.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting first: poles, equator, last point, first index past the end.
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd499);
        send_index(16'd500);
        send_index(16'd998);
        send_index(16'd999);
        send_index(16'd1000);
        send_index(16'hFFFF);
        drain();
        // Two-point lattice at the largest radius: only the two poles exist.
        set_lattice(16'd2, 16'hFFFF);
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd2);
        send_index(16'hAAAA);
        drain();
        set_lattice(16'hFFFF, 16'd0);
        send_index(16'd0);
        send_index(16'h5555);
        send_index(16'hFFFE);
        send_index(16'hFFFF);
        drain();
        set_lattice(16'hFFFF, 16'hFFFF);
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'h7FFF);
        send_index(16'hFFFD);
        send_index(16'hFFFE);
        drain();
        set_lattice(16'd3, 16'd1);
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd2);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin n = 16'hFFFF; r = 16'hFFFF; end
                1: begin n = 16'd2; r = 16'($urandom); end
                2: begin n = 16'hFFFF; r = 16'd0; end
                default:
                begin
                    n = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(2, 64))
                                                    : 16'($urandom_range(2, 65535));
                    r = 16'($urandom);
                end
            endcase
            set_lattice(n, r);
            if (ph == 3)
            begin
                // Hold the output long enough for the pipeline to back up.
                idle_en = 1'b0;
                long_hold_req = 200;
                random_points(100);
                idle_en = 1'b1;
            end
            if (ph == 7)
                idle_en = 1'b0;
            random_points(150);
            drain();
        end

        if (sb.pending_points.size() == 0 && sb.mismatches == 0)
            $display("tb_fibonacci_sphere_points OK");
        else
            $display("tb_fibonacci_sphere_points NOT OK");
        $finish;
    end

endmodule
